>>> rtl/core/dqap_pkg.sv
// ----------------------------------------------------------------------------
// dqap_pkg
// Shared types and character constants for the dotted-quad address parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dqap_pkg;

    // character codes
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    // part bookkeeping
    localparam logic [2:0] NUM_PARTS = 3'd4;   // dot count saturates here
    localparam logic [2:0] LAST_PART = 3'd3;   // index of the fourth part
    localparam logic [8:0] VALUE_SAT = 9'd256;

    // character class decided by the front end
    typedef enum logic [2:0] {
        CLS_NONE,    // word carries no character
        CLS_DOT,
        CLS_DIGIT,
        CLS_BLANK,
        CLS_PLUS,
        CLS_MINUS,
        CLS_OTHER
    } t_cls;

    // classified word as held in the queue
    typedef struct packed {
        t_cls       cls;
        logic [3:0] digit;
        logic       last;
    } t_tok;

    // queue head as seen by the back end
    typedef struct packed {
        logic valid;
        t_tok tok;
    } t_head;

endpackage

`default_nettype wire

>>> rtl/core/dqap_in_if.sv
// ----------------------------------------------------------------------------
// dqap_in_if
// Character channel: one character of the line per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface dqap_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       has_char;
    logic       last;

    modport source (output valid, output ch, output has_char, output last, input ready);
    modport sink   (input valid, input ch, input has_char, input last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/dqap_out_if.sv
// ----------------------------------------------------------------------------
// dqap_out_if
// Result channel: validity flag and the 32-bit address.
// ----------------------------------------------------------------------------
`default_nettype none

interface dqap_out_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic [31:0] address;

    modport source (output valid, output ok, output address, input ready);
    modport sink   (input valid, input ok, input address, output ready);
endinterface

`default_nettype wire

>>> rtl/core/dotted_quad_address_parser_core.sv
// ----------------------------------------------------------------------------
// dotted_quad_address_parser_core
// Checks a text line, one character per word, as a dotted-decimal IPv4
// address and returns a valid flag plus the 32-bit address per line.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  i_in    | in  | valid/ready   | ch[7:0], has_char, last
//  o_out   | out | valid/ready   | ok, address[31:0] (first part in 31..24)
//
//  One character word per cycle while the queue has room; the queue takes
//  words while the parser drains them, so i_in.ready drops only when the
//  queue is full. The closing word is written into the queue, then parsed
//  into the result register that drives o_out.valid.
//  The parser stalls only on a closing word while the result register is
//  still held by o_out.ready low; other words keep flowing.
//  i_rst_n is synchronous and clears queue pointers and parser state; no
//  clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module dotted_quad_address_parser_core
    import dqap_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4   // classified words held between front and back
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    dqap_in_if.sink     i_in,
    dqap_out_if.source  o_out
);

    t_head w_head;   // queue head: valid flag and classified word
    logic  w_pop;    // back end consumes the head word

    // front: classify each character and queue it
    dqap_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    // back: part state machine and result register
    dqap_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

>>> rtl/core/dqap_front.sv
// ----------------------------------------------------------------------------
// dqap_front
// Accepts characters, classifies them and queues the classified words.
// ----------------------------------------------------------------------------
`default_nettype none

module dqap_front
    import dqap_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    dqap_in_if.sink     i_in,
    output t_head       o_head,
    input  wire         i_pop
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_tok          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    t_tok  w_tok;
    logic  w_full;
    logic  w_push;

    // classify
    always_comb begin
        w_tok.last  = i_in.last;
        w_tok.digit = 4'(i_in.ch - CH_ZERO);
        if (!i_in.has_char) begin
            w_tok.cls = CLS_NONE;
        end else if (i_in.ch == CH_DOT) begin
            w_tok.cls = CLS_DOT;
        end else if (i_in.ch >= CH_ZERO && i_in.ch <= CH_NINE) begin
            w_tok.cls = CLS_DIGIT;
        end else if (i_in.ch == CH_SPACE || (i_in.ch >= CH_HT && i_in.ch <= CH_CR)) begin
            w_tok.cls = CLS_BLANK;
        end else if (i_in.ch == CH_PLUS) begin
            w_tok.cls = CLS_PLUS;
        end else if (i_in.ch == CH_MINUS) begin
            w_tok.cls = CLS_MINUS;
        end else begin
            w_tok.cls = CLS_OTHER;
        end
    end

    assign w_full      = (r_cnt == CW'(DEPTH));
    assign i_in.ready  = !w_full;
    // empty non-closing words do nothing; taken but dropped
    assign w_push      = i_in.valid && !w_full && (i_in.has_char || i_in.last);

    assign o_head.valid = (r_cnt != '0);
    assign o_head.tok   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            r_cnt <= r_cnt + CW'(w_push) - CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= w_tok;
        end
    end

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("queue count above depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != '0)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

>>> rtl/core/dqap_back.sv
// ----------------------------------------------------------------------------
// dqap_back
// Parses queued words into parts and registers the line result.
// ----------------------------------------------------------------------------
`default_nettype none

module dqap_back
    import dqap_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire t_head  i_head,
    output logic        o_pop,
    dqap_out_if.source  o_out
);

    typedef enum logic [1:0] {
        PH_SPACE,
        PH_SIGN,
        PH_DIGITS
    } t_phase;

    t_phase      r_phase;
    logic [2:0]  r_part_idx;
    logic        r_minus;
    logic        r_digit;
    logic [8:0]  r_value;
    logic        r_bad;
    logic [7:0]  r_oct [3];
    logic        r_out_valid;
    logic        r_ok;
    logic [31:0] r_addr;

    t_phase      n_phase;
    logic [2:0]  n_idx;
    logic        n_minus;
    logic        n_digit;
    logic [8:0]  n_value;
    logic        n_bad;
    logic        c_store;
    logic [11:0] c_prod;
    logic        c_fin_bad;
    logic        c_ok;
    logic        w_fin;

    assign w_fin = o_pop && i_head.tok.last;
    assign o_pop = i_head.valid && (!i_head.tok.last || !r_out_valid || o_out.ready);

    // effect of one character on the part state
    always_comb begin
        n_phase = r_phase;
        n_idx   = r_part_idx;
        n_minus = r_minus;
        n_digit = r_digit;
        n_value = r_value;
        n_bad   = r_bad;
        c_store = 1'b0;
        c_prod  = ({3'b0, r_value} << 3) + ({3'b0, r_value} << 1) + {8'b0, i_head.tok.digit};
        case (i_head.tok.cls)
            CLS_DOT: begin
                if (!r_digit || r_value[8] || (r_minus && r_value != '0)) begin
                    n_bad = 1'b1;
                end
                c_store = (r_part_idx < LAST_PART);
                if (r_part_idx < NUM_PARTS) begin
                    n_idx = r_part_idx + 3'd1;
                end
                n_phase = PH_SPACE;
                n_minus = 1'b0;
                n_digit = 1'b0;
                n_value = '0;
            end
            CLS_DIGIT: begin
                n_value = (c_prod > 12'(VALUE_SAT)) ? VALUE_SAT : c_prod[8:0];
                n_digit = 1'b1;
                n_phase = PH_DIGITS;
            end
            CLS_BLANK: begin
                if (r_phase != PH_SPACE) begin
                    n_bad = 1'b1;
                end
            end
            CLS_PLUS, CLS_MINUS: begin
                if (r_phase == PH_SPACE) begin
                    n_minus = (i_head.tok.cls == CLS_MINUS);
                    n_phase = PH_SIGN;
                end else begin
                    n_bad = 1'b1;
                end
            end
            CLS_OTHER: begin
                n_bad = 1'b1;
            end
            default: begin
            end
        endcase
        // closing check of the final part
        c_fin_bad = n_bad || !n_digit || n_value[8] || (n_minus && n_value != '0);
        c_ok      = !c_fin_bad && (n_idx == LAST_PART);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SPACE;
            r_part_idx  <= '0;
            r_minus     <= 1'b0;
            r_digit     <= 1'b0;
            r_value     <= '0;
            r_bad       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fin) begin
                r_out_valid <= 1'b1;
                r_ok        <= c_ok;
                r_addr      <= c_ok ? {r_oct[0], r_oct[1], r_oct[2], n_value[7:0]} : '0;
                r_phase     <= PH_SPACE;
                r_part_idx  <= '0;
                r_minus     <= 1'b0;
                r_digit     <= 1'b0;
                r_value     <= '0;
                r_bad       <= 1'b0;
            end else begin
                if (o_out.ready) begin
                    r_out_valid <= 1'b0;
                end
                if (o_pop) begin
                    r_phase    <= n_phase;
                    r_part_idx <= n_idx;
                    r_minus    <= n_minus;
                    r_digit    <= n_digit;
                    r_value    <= n_value;
                    r_bad      <= n_bad;
                end
            end
            if (o_pop && c_store) begin
                r_oct[r_part_idx[1:0]] <= r_value[7:0];
            end
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.ok      = r_ok;
    assign o_out.address = r_addr;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_part_idx <= NUM_PARTS)
        else $error("part index out of range");

    a_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_ok |-> r_addr == '0)
        else $error("address not zero on a failed line");

    a_fin_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin |=> r_out_valid && r_part_idx == '0 && !r_bad)
        else $error("closing word did not produce a result and clear state");

endmodule

`default_nettype wire
